>>> hw/rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler package
// Shared widths, CORDIC angle table and the CORDIC step record.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int QuatWidth      = 16;
   localparam int AngWidth       = 16;
   localparam int PitchWidth     = 15;
   // Q2.30 products and sums of two stay below 2^32 in magnitude
   localparam int VecWidth       = 36;
   localparam int ZWidth         = 34;
   localparam int CordicSteps    = 16;
   localparam int MaxSteps       = 24;
   localparam int AngLimitFull   = 25736;
   localparam int AngLimitHalf   = 12868;
   localparam logic signed [ZWidth-1:0] HalfPiQ30 = ZWidth'(64'sd1686629713);

   typedef logic signed [VecWidth-1:0] vec_type;
   typedef logic signed [ZWidth-1:0]   ang_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
   } cordic_type;

   function automatic ang_type atan_entry(input int idx);
      case (idx)
         0:  atan_entry = ZWidth'(34'h03243F6A8);
         1:  atan_entry = ZWidth'(34'h01DAC6705);
         2:  atan_entry = ZWidth'(34'h00FADBAFC);
         3:  atan_entry = ZWidth'(34'h007F56EA6);
         4:  atan_entry = ZWidth'(34'h003FEAB76);
         5:  atan_entry = ZWidth'(34'h001FFD55B);
         6:  atan_entry = ZWidth'(34'h000FFFAAA);
         7:  atan_entry = ZWidth'(34'h0007FFF55);
         8:  atan_entry = ZWidth'(34'h0003FFFEA);
         9:  atan_entry = ZWidth'(34'h0001FFFFD);
         10: atan_entry = ZWidth'(34'h0000FFFFF);
         11: atan_entry = ZWidth'(34'h00007FFFF);
         12: atan_entry = ZWidth'(34'h00003FFFF);
         13: atan_entry = ZWidth'(34'h00001FFFF);
         14: atan_entry = ZWidth'(34'h00000FFFF);
         15: atan_entry = ZWidth'(34'h000007FFF);
         16: atan_entry = ZWidth'(34'h000003FFF);
         17: atan_entry = ZWidth'(34'h000001FFF);
         18: atan_entry = ZWidth'(34'h000000FFF);
         19: atan_entry = ZWidth'(34'h0000007FF);
         20: atan_entry = ZWidth'(34'h0000003FF);
         21: atan_entry = ZWidth'(34'h0000001FF);
         22: atan_entry = ZWidth'(34'h0000000FF);
         23: atan_entry = ZWidth'(34'h00000007F);
         default: atan_entry = '0;
      endcase
   endfunction

   // Quadrant fold before the micro-rotations
   function automatic cordic_type cordic_pre(input vec_type x, input vec_type y);
      cordic_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.z = HalfPiQ30;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -HalfPiQ30;
         end
      end
      return r;
   endfunction

   // One vectoring micro-rotation
   function automatic cordic_type cordic_step(input cordic_type c, input int idx);
      cordic_type r;
      vec_type xs;
      vec_type ys;
      xs = c.x >>> idx;
      ys = c.y >>> idx;
      if (c.y >= 0) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + atan_entry(idx);
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - atan_entry(idx);
      end
      return r;
   endfunction

   // Round to Q3.13 and clamp
   function automatic logic signed [AngWidth-1:0] to_q13(input ang_type z, input int lim);
      logic signed [ZWidth:0] s;
      logic signed [ZWidth-17:0] r;
      s = {z[ZWidth-1], z} + (ZWidth+1)'(65536);
      r = s[ZWidth:17];
      if (r > lim)
         to_q13 = AngWidth'(lim);
      else if (r < -lim)
         to_q13 = AngWidth'(-lim);
      else
         to_q13 = AngWidth'(r);
   endfunction

endpackage

>>> hw/rtl/quaternion_to_euler_zyx.sv
// Throughput: one item per cycle; busy stays low, results cannot be stalled.
// Depth: three product/sum/square stages, 16 square-root stages (two root bits each
// but one in the last), a quadrant-fold stage, one per CORDIC step, output register.
// Reset: synchronous, clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
// Quaternion to Z-Y-X Euler angles
// Pipelined products, square root and three CORDIC arctangent lanes.
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx #(
   parameter int CORDIC_STEPS = q2e_pkg::CordicSteps
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [q2e_pkg::QuatWidth-1:0]  req_quat_w,
   input  logic signed [q2e_pkg::QuatWidth-1:0]  req_quat_x,
   input  logic signed [q2e_pkg::QuatWidth-1:0]  req_quat_y,
   input  logic signed [q2e_pkg::QuatWidth-1:0]  req_quat_z,
   output logic rsp_valid,
   output logic signed [q2e_pkg::AngWidth-1:0]   rsp_roll,
   output logic signed [q2e_pkg::PitchWidth-1:0] rsp_pitch,
   output logic signed [q2e_pkg::AngWidth-1:0]   rsp_yaw,
   output logic rsp_pitch_clamped
);
   import q2e_pkg::*;

   localparam int Steps   = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

   assign busy = 1'b0;

   // ---------------- stage 1: products ----------------
   logic v1_ff;
   logic signed [31:0] ww_ff, xx_ff, zz_ff, wx_ff, yz_ff, wz_ff, xy_ff, xz_ff, wy_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      ww_ff <= req_quat_w * req_quat_w;
      xx_ff <= req_quat_x * req_quat_x;
      zz_ff <= req_quat_z * req_quat_z;
      wx_ff <= req_quat_w * req_quat_x;
      yz_ff <= req_quat_y * req_quat_z;
      wz_ff <= req_quat_w * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      xz_ff <= req_quat_x * req_quat_z;
      wy_ff <= req_quat_w * req_quat_y;
   end

   // ---------------- stage 2: sums and arcsine argument ----------------
   logic    v2_ff;
   vec_type rx_ff, ry_ff, yx_ff, yy_ff, a_ff;
   logic    flag2_ff;
   vec_type a_in;
   logic    flag_in;

   always_comb begin
      a_in = -(VecWidth'(xz_ff) - VecWidth'(wy_ff)) <<< 1;
      flag_in = 1'b0;
      if (a_in > vec_type'(64'sd1073741824)) begin
         a_in = vec_type'(64'sd1073741824);
         flag_in = 1'b1;
      end else if (a_in < -vec_type'(64'sd1073741824)) begin
         a_in = -vec_type'(64'sd1073741824);
         flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      ry_ff <= VecWidth'(wx_ff) + VecWidth'(yz_ff);
      rx_ff <= VecWidth'(ww_ff) + VecWidth'(zz_ff) - vec_type'(64'sd536870912);
      yy_ff <= VecWidth'(wz_ff) + VecWidth'(xy_ff);
      yx_ff <= VecWidth'(ww_ff) + VecWidth'(xx_ff) - vec_type'(64'sd536870912);
      a_ff <= a_in;
      flag2_ff <= flag_in;
   end

   // ---------------- stage 3: a squared, radicand ----------------
   // |a| <= 2^30, so its magnitude squares in one 31x31 multiply.
   logic v3_ff;
   logic [60:0] rad_ff;
   logic [30:0] aabs;
   assign aabs = a_ff[VecWidth-1] ? 31'(-a_ff) : 31'(a_ff);

   logic [61:0] asq;
   assign asq = aabs * aabs;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      rad_ff <= 61'((62'd1 << 60) - asq);
   end

   // pass-through payload alongside the square root
   typedef struct packed {
      vec_type rx;
      vec_type ry;
      vec_type yx;
      vec_type yy;
      vec_type a;
      logic    flag;
   } side_type;

   side_type s3_ff;
   always_ff @(posedge clock) begin
      s3_ff <= '{rx: rx_ff, ry: ry_ff, yx: yx_ff, yy: yy_ff, a: a_ff, flag: flag2_ff};
   end

   // ---------------- pipelined square root, two root bits per stage ----------
   // restoring method on a 61-bit radicand: 31 root bits, two bits per stage
   localparam int RootBits = 31;
   localparam int RootStages = (RootBits + 1) / 2;

   logic        sv_ff   [RootStages+1];
   logic [61:0] rem_ff  [RootStages+1];
   logic [30:0] root_ff [RootStages+1];
   side_type    sd_ff   [RootStages+1];

   assign sv_ff[0]   = v3_ff;
   assign rem_ff[0]  = 62'(rad_ff);
   assign root_ff[0] = '0;
   assign sd_ff[0]   = s3_ff;

   for (genvar g = 0; g < RootStages; g++) begin : g_sqrt
      logic [61:0] rem_n;
      logic [30:0] root_n;
      always_comb begin
         logic [63:0] trial;
         trial = '0;
         rem_n = rem_ff[g];
         root_n = root_ff[g];
         for (int b = 0; b < 2; b++) begin
            int bit_idx;
            bit_idx = RootBits - 1 - 2*g - b;
            if (bit_idx >= 0) begin
               trial = 64'(root_n) << (bit_idx + 1);
               trial = trial + (64'd1 << (2*bit_idx));
               if (64'(rem_n) >= trial) begin
                  rem_n = 62'(64'(rem_n) - trial);
                  root_n[bit_idx] = 1'b1;
               end
            end
         end
      end
      logic        v_r;
      logic [61:0] rem_r;
      logic [30:0] root_r;
      side_type    sd_r;
      always_ff @(posedge clock) begin
         if (reset) v_r <= 1'b0;
         else v_r <= sv_ff[g];
         rem_r  <= rem_n;
         root_r <= root_n;
         sd_r   <= sd_ff[g];
      end
      assign sv_ff[g+1]   = v_r;
      assign rem_ff[g+1]  = rem_r;
      assign root_ff[g+1] = root_r;
      assign sd_ff[g+1]   = sd_r;
   end

   // ---------------- CORDIC pre-rotation stage ----------------
   logic       cv_ff [Steps+1];
   cordic_type cr_ff [Steps+1];
   cordic_type cp_ff [Steps+1];
   cordic_type cy_ff [Steps+1];
   logic       cf_ff [Steps+1];

   logic       pv_ff;
   cordic_type pr_ff, pp_ff, py_ff;
   logic       pzr_ff, pzp_ff, pzy_ff, pfl_ff;
   side_type   sq;
   vec_type    cval;
   assign sq = sd_ff[RootStages];
   assign cval = VecWidth'(root_ff[RootStages]);

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= sv_ff[RootStages];
      pr_ff  <= cordic_pre(sq.rx, sq.ry);
      pp_ff  <= cordic_pre(cval, sq.a);
      py_ff  <= cordic_pre(sq.yx, sq.yy);
      pzr_ff <= (sq.rx == 0) && (sq.ry == 0);
      pzp_ff <= (cval == 0) && (sq.a == 0);
      pzy_ff <= (sq.yx == 0) && (sq.yy == 0);
      pfl_ff <= sq.flag;
   end

   // zero-vector marks packed in one 3-bit lane
   logic [2:0] zm_ff [Steps+1];
   assign cv_ff[0] = pv_ff;
   assign cr_ff[0] = pr_ff;
   assign cp_ff[0] = pp_ff;
   assign cy_ff[0] = py_ff;
   assign zm_ff[0] = {pzr_ff, pzp_ff, pzy_ff};
   assign cf_ff[0] = pfl_ff;

   // ---------------- CORDIC micro-rotations, one per stage ----------------
   for (genvar s = 0; s < Steps; s++) begin : g_cordic
      logic       v_r, f_r;
      logic [2:0] zm_r;
      cordic_type r_r, p_r, y_r;
      always_ff @(posedge clock) begin
         if (reset) v_r <= 1'b0;
         else v_r <= cv_ff[s];
         r_r  <= cordic_step(cr_ff[s], s);
         p_r  <= cordic_step(cp_ff[s], s);
         y_r  <= cordic_step(cy_ff[s], s);
         zm_r <= zm_ff[s];
         f_r  <= cf_ff[s];
      end
      assign cv_ff[s+1] = v_r;
      assign cr_ff[s+1] = r_r;
      assign cp_ff[s+1] = p_r;
      assign cy_ff[s+1] = y_r;
      assign zm_ff[s+1] = zm_r;
      assign cf_ff[s+1] = f_r;
   end

   // ---------------- output register: round, clamp ----------------
   ang_type zr, zp, zy;
   logic signed [AngWidth-1:0] pw;
   assign zr = zm_ff[Steps][2] ? '0 : cr_ff[Steps].z;
   assign zp = zm_ff[Steps][1] ? '0 : cp_ff[Steps].z;
   assign zy = zm_ff[Steps][0] ? '0 : cy_ff[Steps].z;
   assign pw = to_q13(zp, AngLimitHalf);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cv_ff[Steps];
      rsp_roll          <= to_q13(zr, AngLimitFull);
      rsp_pitch         <= pw[PitchWidth-1:0];
      rsp_yaw           <= to_q13(zy, AngLimitFull);
      rsp_pitch_clamped <= cf_ff[Steps];
   end

   // ---------------- assertions ----------------
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch <= 15'sd12868 && rsp_pitch >= -15'sd12868))
      else $error("pitch out of range");
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll <= 16'sd25736 && rsp_roll >= -16'sd25736))
      else $error("roll out of range");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion to Euler angle checker
// Drives quaternions with random gaps, predicts roll, pitch, yaw and the
// arcsine saturation flag in fixed point, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;

   import q2e_pkg::*;

   localparam int  Steps       = CordicSteps;
   localparam int  RandomItems = 1400;
   localparam int  IdleLimit   = 2000;
   localparam int  DrainCycles = 3 + 18 + Steps + 20;
   localparam longint OneQ30   = 64'sd1 << 30;
   localparam longint HalfQ30  = 64'sd1 << 29;
   localparam longint HalfPi   = 64'sd1686629713;

   typedef struct packed {
      logic signed [QuatWidth-1:0] w;
      logic signed [QuatWidth-1:0] x;
      logic signed [QuatWidth-1:0] y;
      logic signed [QuatWidth-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [AngWidth-1:0]   roll;
      logic signed [PitchWidth-1:0] pitch;
      logic signed [AngWidth-1:0]   yaw;
      logic                         clamped;
   } euler_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [QuatWidth-1:0]  req_quat_w;
   logic signed [QuatWidth-1:0]  req_quat_x;
   logic signed [QuatWidth-1:0]  req_quat_y;
   logic signed [QuatWidth-1:0]  req_quat_z;
   logic rsp_valid;
   logic signed [AngWidth-1:0]   rsp_roll;
   logic signed [PitchWidth-1:0] rsp_pitch;
   logic signed [AngWidth-1:0]   rsp_yaw;
   logic rsp_pitch_clamped;

   quat_type  quat_pending[$];
   euler_type angles_expected[$];
   logic      took;
   int        gap;
   int        idle_cycles;
   int        errors;

   quaternion_to_euler_zyx dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_roll(rsp_roll), .rsp_pitch(rsp_pitch),
      .rsp_yaw(rsp_yaw), .rsp_pitch_clamped(rsp_pitch_clamped)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Exact floor square root
   function automatic longint floor_sqrt(input longint n);
      longint res;
      longint bit_val;
      res = 0;
      bit_val = 64'sd1 << 62;
      while (bit_val > n) bit_val = bit_val >>> 2;
      while (bit_val != 0) begin
         if (n >= res + bit_val) begin
            n = n - (res + bit_val);
            res = (res >>> 1) + bit_val;
         end else begin
            res = res >>> 1;
         end
         bit_val = bit_val >>> 2;
      end
      return res;
   endfunction

   // Vectoring arctangent, angle in units of 2^-30 rad
   function automatic longint vector_angle(input longint vy, input longint vx);
      longint ang;
      longint t;
      longint xs;
      longint ys;
      if (vx == 0 && vy == 0) return 0;
      ang = 0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy; vy = -t; ang = HalfPi;
         end else begin
            vx = -vy; vy = t; ang = -HalfPi;
         end
      end
      for (int i = 0; i < Steps && i < MaxSteps; i++) begin
         xs = vx >>> i;
         ys = vy >>> i;
         if (vy >= 0) begin
            vx = vx + ys; vy = vy - xs; ang = ang + longint'(atan_entry(i));
         end else begin
            vx = vx - ys; vy = vy + xs; ang = ang - longint'(atan_entry(i));
         end
      end
      return ang;
   endfunction

   function automatic longint round_q13(input longint ang, input longint lim);
      longint r;
      r = (ang + (64'sd1 << 16)) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type quat_to_euler(input quat_type q);
      euler_type e;
      longint w, x, y, z, a, c;
      w = q.w; x = q.x; y = q.y; z = q.z;
      e.roll = AngWidth'(round_q13(vector_angle(w * x + y * z, w * w + z * z - HalfQ30),
                                   AngLimitFull));
      e.clamped = 1'b0;
      a = -2 * (x * z - w * y);
      if (a > OneQ30) begin a = OneQ30; e.clamped = 1'b1; end
      if (a < -OneQ30) begin a = -OneQ30; e.clamped = 1'b1; end
      c = floor_sqrt((64'sd1 << 60) - a * a);
      e.pitch = PitchWidth'(round_q13(vector_angle(a, c), AngLimitHalf));
      e.yaw = AngWidth'(round_q13(vector_angle(w * z + x * y, w * w + x * x - HalfQ30),
                                  AngLimitFull));
      return e;
   endfunction

   function automatic quat_type make_quat(input int w, input int x, input int y, input int z);
      quat_type q;
      q.w = QuatWidth'(w); q.x = QuatWidth'(x); q.y = QuatWidth'(y); q.z = QuatWidth'(z);
      return q;
   endfunction

   function automatic logic [QuatWidth-1:0] rand_comp(input bit narrow);
      if (narrow) return QuatWidth'($urandom_range(0, 32768) - 16384);
      return QuatWidth'($urandom);
   endfunction

   // Fill the pending queue: directed corners, then random quaternions
   initial begin
      quat_pending.push_back(make_quat(0, 0, 0, 0));               // negative x axis
      quat_pending.push_back(make_quat(32767, 0, 0, 0));           // identity
      quat_pending.push_back(make_quat(-32768, -32768, -32768, -32768));
      quat_pending.push_back(make_quat(32767, 32767, 32767, 32767));
      quat_pending.push_back(make_quat(-32768, 32767, -32768, 32767));
      quat_pending.push_back(make_quat(16384, 0, 0, 16384));       // roll of zero vector
      quat_pending.push_back(make_quat(16384, 0, 16384, 0));       // roll and yaw on negative x axis
      quat_pending.push_back(make_quat(32767, 0, 32767, 0));       // saturated positive
      quat_pending.push_back(make_quat(32767, 0, -32768, 0));      // saturated negative
      quat_pending.push_back(make_quat(16384, -16384, 16384, 16384)); // exactly +1
      quat_pending.push_back(make_quat(16384, 16384, -16384, 16384)); // exactly -1
      quat_pending.push_back(make_quat(23170, 23170, 0, 0));       // roll pi/2
      quat_pending.push_back(make_quat(23170, 0, 0, 23170));       // yaw pi/2
      quat_pending.push_back(make_quat(0, 32767, 0, 0));           // roll pi
      quat_pending.push_back(make_quat(0, 0, 0, -32768));          // yaw pi
      quat_pending.push_back(make_quat(1, -1, 1, -1));
      quat_pending.push_back(make_quat(-1, 1, -1, 1));
      quat_pending.push_back(make_quat(0, 0, 32767, 0));
      for (int i = 0; i < RandomItems; i++) begin
         bit narrow;
         narrow = ($urandom_range(0, 2) != 0);
         quat_pending.push_back(make_quat(rand_comp(narrow), rand_comp(narrow),
                                          rand_comp(narrow), rand_comp(narrow)));
      end
   end

   // Reset once, then release on a falling edge
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: hold an item until its transfer, then wait a random gap
   initial begin
      start = 1'b0; gap = 0;
      req_quat_w = '0; req_quat_x = '0; req_quat_y = '0; req_quat_z = '0;
   end

   always @(negedge clock) begin
      quat_type q;
      if (!reset && !(start && !took)) begin
         if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
         end else if (quat_pending.size() != 0) begin
            q = quat_pending.pop_front();
            req_quat_w <= q.w; req_quat_x <= q.x; req_quat_y <= q.y; req_quat_z <= q.z;
            start <= 1'b1;
            gap <= $urandom_range(0, 3);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on each input transfer, check on each result strobe
   initial begin took = 1'b0; errors = 0; idle_cycles = 0; end

   always @(posedge clock) begin
      euler_type got;
      euler_type want;
      took <= start && !busy && !reset;
      if (!reset && start && !busy)
         angles_expected.push_back(quat_to_euler({req_quat_w, req_quat_x,
                                                  req_quat_y, req_quat_z}));
      if (!reset && rsp_valid) begin
         got = {rsp_roll, rsp_pitch, rsp_yaw, rsp_pitch_clamped};
         if (angles_expected.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d clamped=%0b",
                     $time, got.roll, got.pitch, got.yaw, got.clamped);
            errors++;
         end else begin
            want = angles_expected.pop_front();
            if (got.roll !== want.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
               errors++;
            end
            if (got.pitch !== want.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
               errors++;
            end
            if (got.yaw !== want.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
               errors++;
            end
            if (got.clamped !== want.clamped) begin
               $display("%0t: pitch_clamped expected %0b actual %0b",
                        $time, want.clamped, got.clamped);
               errors++;
            end
         end
      end
      // Watchdog on cycles without any transfer
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // Finish: drain, then report
   initial begin
      @(negedge reset);
      fork
         begin
            wait (quat_pending.size() == 0 && !start && angles_expected.size() == 0);
            repeat (DrainCycles) @(posedge clock);
            if (errors == 0) $display("PASS");
            else $display("FAIL");
            $finish;
         end
         begin
            wait (idle_cycles >= IdleLimit);
            $display("FAIL");
            $finish;
         end
      join
   end

endmodule
